[hdl/ntrt_pkg.sv]
// Shared types and constants for the transmit ring / receive pointer tracker.
// Used by ntrt_ctrl, ntrt_dp and nic_tx_rx_ring_tracker_core. No dependencies.
package ntrt_pkg;

  // Event codes carried by the opcode field of a request.
  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_TXDONE = 2'd1,
    OP_RXHDR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_FULL = 2'd1,
    ST_DROP = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TXD  = 5'b00100,
    S_TXK  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  // Minimum transmit frame length in bytes.
  localparam logic [15:0] MIN_FRAME = 16'd60;
  // Last byte offset usable before the 64 KiB receive ring end, minus the header.
  localparam logic [15:0] RX_FIRST_BASE = 16'hFFFC;
  // Receive ring size in bytes, 18 bits wide to compare against grown sums.
  localparam logic [17:0] RX_RING_BYTES = 18'd65536;
  // Receive header size and the card's release offset.
  localparam logic [17:0] RX_HDR_BYTES = 18'd4;
  localparam logic [15:0] RX_RELEASE_OFS = 16'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the request and start a scan at the head
    logic scan_step;   // move the scan to the next slot
    logic send_take;   // claim the scanned slot and load the send result
    logic send_full;   // load the ring-full result
    logic tx_advance;  // free the head slot, advance the head, read its length
    logic tx_load;     // load the transmit-done result
    logic ev_load;     // load the receive result (or an empty one)
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e op;
    logic    slot_free;
    logic    scan_last;
    logic    out_free;
  } sts_t;

endpackage

[hdl/ntrt_ctrl.sv]
// Controller state machine of the ring tracker: sequences one request at a time.
// Depends on ntrt_pkg.
module ntrt_ctrl
  import ntrt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (sts_i.slot_free) begin
          if (sts_i.out_free) begin
            cmd_o.send_take = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.scan_last) begin
          if (sts_i.out_free) begin
            cmd_o.send_full = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_TXD: begin
        cmd_o.tx_advance = 1'b1;
        state_d = S_TXK;
      end
      S_TXK: begin
        if (sts_i.out_free) begin
          cmd_o.tx_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        // The opcode was latched on acceptance; branch on it here.
        case (sts_i.op)
          OP_SEND: state_d = S_SCAN;
          OP_TXDONE: state_d = S_TXD;
          default: begin
            if (sts_i.out_free) begin
              cmd_o.ev_load = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_take_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.send_take || cmd_o.send_full || cmd_o.tx_load || cmd_o.ev_load)
      |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  a_txd_then_txk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tx_advance |=> (state_q == S_TXK))
    else $error("head advance not followed by kick check");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_FIN))
    else $error("accepted request not dispatched");

endmodule

[hdl/ntrt_dp.sv]
// Datapath of the ring tracker: slot flags, slot length memory, head and
// receive pointers, scan counter and the result register. Depends on ntrt_pkg.
module ntrt_dp
  import ntrt_pkg::*;
#(
  parameter int TX_SLOTS   = 16,
  parameter int MAX_PACKET = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] packet_length_i,
  input  logic        header_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic [15:0] padded_length_o,
  output logic        kick_valid_o,
  output logic [1:0]  kick_port_o,
  output logic [3:0]  kick_slot_o,
  output logic [15:0] kick_length_o,
  output logic        rx_deliver_o,
  output logic        rx_split_o,
  output logic [15:0] rx_first_length_o,
  output logic [15:0] rx_read_pointer_o,
  output logic [15:0] rx_release_value_o
);

  localparam int SW = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(TX_SLOTS - 1);

  // Request fields, held for the life of the request.
  opcode_e     op_q;
  logic [15:0] len_q;
  logic        ok_q;

  logic [TX_SLOTS-1:0] busy_q;
  logic [SW-1:0]       head_q, head_d, head_inc;
  logic [SW-1:0]       scan_q, scan_inc, cnt_q;
  logic [15:0]         rx_q;

  logic [15:0] mem [TX_SLOTS];
  logic [15:0] rd_q;

  // Result register.
  logic        out_valid_q;
  status_e     status_q;
  logic [3:0]  slot_index_q, kick_slot_q;
  logic [15:0] padded_q, kick_length_q;
  logic        kick_valid_q, rx_deliver_q, rx_split_q;
  logic [1:0]  kick_port_q;
  logic [15:0] rx_first_q, rx_ptr_q, rx_rel_q;

  // Next result values.
  status_e     res_status;
  logic [3:0]  res_slot, res_kslot;
  logic [15:0] res_padded, res_klen;
  logic        res_kvalid, res_deliver, res_split;
  logic [1:0]  res_kport;
  logic [15:0] res_first, res_ptr, res_rel;

  logic        load;
  logic [15:0] padded;
  logic [SW+3:0] scan_ext, head_ext;
  logic [17:0] rx_sum, rx_round;
  logic        rx_ok;

  assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + SW'(1);
  assign scan_inc = (scan_q == LAST_SLOT) ? '0 : scan_q + SW'(1);
  assign head_d   = cmd_i.tx_advance ? head_inc : head_q;

  assign scan_ext = {4'b0000, scan_q};
  assign head_ext = {4'b0000, head_q};
  assign padded   = (len_q < MIN_FRAME) ? MIN_FRAME : len_q;

  assign rx_sum   = {2'b00, rx_q} + {2'b00, len_q} + RX_HDR_BYTES;
  assign rx_round = rx_sum + 18'd3;
  assign rx_ok    = ok_q && (len_q < 16'(MAX_PACKET));

  assign load = cmd_i.send_take || cmd_i.send_full || cmd_i.tx_load || cmd_i.ev_load;

  assign sts_o.op        = op_q;
  assign sts_o.slot_free = !busy_q[scan_q];
  assign sts_o.scan_last = (cnt_q == LAST_SLOT);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    res_status  = ST_GOOD;
    res_slot    = '0;
    res_padded  = '0;
    res_kvalid  = 1'b0;
    res_kport   = '0;
    res_kslot   = '0;
    res_klen    = '0;
    res_deliver = 1'b0;
    res_split   = 1'b0;
    res_first   = '0;
    res_ptr     = '0;
    res_rel     = '0;
    if (cmd_i.send_full) begin
      res_status = ST_FULL;
    end else if (cmd_i.send_take) begin
      res_slot   = scan_ext[3:0];
      res_padded = padded;
      if (scan_q == head_q) begin
        res_kvalid = 1'b1;
        res_kport  = scan_ext[1:0];
        res_kslot  = scan_ext[3:0];
        res_klen   = padded;
      end
    end else if (cmd_i.tx_load) begin
      if (busy_q[head_q]) begin
        res_kvalid = 1'b1;
        res_kport  = head_ext[1:0];
        res_kslot  = head_ext[3:0];
        res_klen   = rd_q;
      end
    end else if (cmd_i.ev_load && (op_q == OP_RXHDR)) begin
      if (rx_ok) begin
        res_deliver = 1'b1;
        if (rx_sum > RX_RING_BYTES) begin
          res_split = 1'b1;
          res_first = RX_FIRST_BASE - rx_q;
        end
      end else begin
        res_status = ST_DROP;
      end
      // Round up to a 4-byte boundary and wrap inside the 64 KiB ring.
      res_ptr = {rx_round[15:2], 2'b00};
      res_rel = {rx_round[15:2], 2'b00} - RX_RELEASE_OFS;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      head_q      <= '0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      if (cmd_i.send_take) begin
        busy_q[scan_q] <= 1'b1;
      end
      if (cmd_i.tx_advance) begin
        busy_q[head_q] <= 1'b0;
      end
      if (cmd_i.ev_load && (op_q == OP_RXHDR)) begin
        rx_q <= res_ptr;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= opcode_e'(opcode_i);
      len_q <= packet_length_i;
      ok_q  <= header_ok_i;
      scan_q <= head_q;
      cnt_q  <= '0;
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_inc;
      cnt_q  <= cnt_q + SW'(1);
    end
    if (load) begin
      status_q      <= res_status;
      slot_index_q  <= res_slot;
      padded_q      <= res_padded;
      kick_valid_q  <= res_kvalid;
      kick_port_q   <= res_kport;
      kick_slot_q   <= res_kslot;
      kick_length_q <= res_klen;
      rx_deliver_q  <= res_deliver;
      rx_split_q    <= res_split;
      rx_first_q    <= res_first;
      rx_ptr_q      <= res_ptr;
      rx_rel_q      <= res_rel;
    end
  end

  // Slot length memory: one write port, one registered read port at the next head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.send_take) begin
      mem[scan_q] <= padded;
    end
    rd_q <= mem[head_d];
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign slot_index_o       = slot_index_q;
  assign padded_length_o    = padded_q;
  assign kick_valid_o       = kick_valid_q;
  assign kick_port_o        = kick_port_q;
  assign kick_slot_o        = kick_slot_q;
  assign kick_length_o      = kick_length_q;
  assign rx_deliver_o       = rx_deliver_q;
  assign rx_split_o         = rx_split_q;
  assign rx_first_length_o  = rx_first_q;
  assign rx_read_pointer_o  = rx_ptr_q;
  assign rx_release_value_o = rx_rel_q;

  a_take_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.send_take |=> busy_q[$past(scan_q)])
    else $error("claimed slot not marked busy");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");

  a_rx_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_q[1:0] == 2'b00)
    else $error("receive pointer lost 4-byte alignment");

endmodule

[hdl/nic_tx_rx_ring_tracker_core.sv]
// Top level of the transmit descriptor ring and receive ring pointer tracker.
// Instantiates ntrt_ctrl and ntrt_dp; depends on ntrt_pkg.
//
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries
// one event: a send request, a transmit-done event or a receive header. Each
// accepted request produces exactly one result on the output channel
// (out_valid_o / out_ready_i), in request order.
// A send request scans the transmit ring from the head for a free slot, one
// slot per cycle, through S_FIN and S_SCAN. A transmit-done event passes
// through S_FIN, S_TXD and S_TXK, as the new head's stored length comes from
// a registered memory read. A receive header, or an unused opcode, gets its
// result loaded from S_FIN. One request is in flight at a time; in_ready_o
// rises again the cycle after the result is loaded into the output register.
// Reset clears the busy flags, the transmit head and the receive pointer; the
// slot length memory is not cleared, as a slot's length is written whenever
// it is claimed. A stalled receiver holds the result in the output register; a
// new request is still taken, and its own result waits until the register
// frees up.
module nic_tx_rx_ring_tracker_core
  import ntrt_pkg::*;
#(
  parameter int TX_SLOTS   = 16,
  parameter int MAX_PACKET = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] packet_length_i,
  input  logic        header_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic [15:0] padded_length_o,
  output logic        kick_valid_o,
  output logic [1:0]  kick_port_o,
  output logic [3:0]  kick_slot_o,
  output logic [15:0] kick_length_o,
  output logic        rx_deliver_o,
  output logic        rx_split_o,
  output logic [15:0] rx_first_length_o,
  output logic [15:0] rx_read_pointer_o,
  output logic [15:0] rx_release_value_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request; it sees the datapath only through
  // the command and status structs.
  ntrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds all ring state and the result register.
  ntrt_dp #(
    .TX_SLOTS   (TX_SLOTS),
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .packet_length_i    (packet_length_i),
    .header_ok_i        (header_ok_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .slot_index_o       (slot_index_o),
    .padded_length_o    (padded_length_o),
    .kick_valid_o       (kick_valid_o),
    .kick_port_o        (kick_port_o),
    .kick_slot_o        (kick_slot_o),
    .kick_length_o      (kick_length_o),
    .rx_deliver_o       (rx_deliver_o),
    .rx_split_o         (rx_split_o),
    .rx_first_length_o  (rx_first_length_o),
    .rx_read_pointer_o  (rx_read_pointer_o),
    .rx_release_value_o (rx_release_value_o)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for nic_tx_rx_ring_tracker_core: directed and random requests,
// with results predicted by a behavioral copy of the tracker state in this file.
// Depends on ntrt_pkg and the RTL of nic_tx_rx_ring_tracker_core.
module testbench
  import ntrt_pkg::*;
();

  localparam int TX_SLOTS   = 16;
  localparam int MAX_PACKET = 2048;
  localparam int PHASE_ITEMS = 667;

  // Expected fields of one result, at the widths of the output ports.
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_index;
    logic [15:0] padded_length;
    logic        kick_valid;
    logic [1:0]  kick_port;
    logic [3:0]  kick_slot;
    logic [15:0] kick_length;
    logic        rx_deliver;
    logic        rx_split;
    logic [15:0] rx_first_length;
    logic [15:0] rx_read_pointer;
    logic [15:0] rx_release_value;
  } tracker_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = 2'd0;
  logic [15:0] packet_length_i = 16'd0;
  logic        header_ok_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  slot_index_o;
  logic [15:0] padded_length_o;
  logic        kick_valid_o;
  logic [1:0]  kick_port_o;
  logic [3:0]  kick_slot_o;
  logic [15:0] kick_length_o;
  logic        rx_deliver_o;
  logic        rx_split_o;
  logic [15:0] rx_first_length_o;
  logic [15:0] rx_read_pointer_o;
  logic [15:0] rx_release_value_o;

  // Shadow of the tracker state.
  logic        slot_busy [TX_SLOTS];
  logic [15:0] slot_len [TX_SLOTS];
  logic [3:0]  tx_head;
  logic [15:0] rx_offset;

  tracker_result_t pending_results[$];
  int mismatch_count = 0;
  int send_gap_pct = 9;
  int recv_stall_pct = 78;

  nic_tx_rx_ring_tracker_core #(
    .TX_SLOTS(TX_SLOTS),
    .MAX_PACKET(MAX_PACKET)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .opcode_i(opcode_i),
    .packet_length_i(packet_length_i),
    .header_ok_i(header_ok_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .slot_index_o(slot_index_o),
    .padded_length_o(padded_length_o),
    .kick_valid_o(kick_valid_o),
    .kick_port_o(kick_port_o),
    .kick_slot_o(kick_slot_o),
    .kick_length_o(kick_length_o),
    .rx_deliver_o(rx_deliver_o),
    .rx_split_o(rx_split_o),
    .rx_first_length_o(rx_first_length_o),
    .rx_read_pointer_o(rx_read_pointer_o),
    .rx_release_value_o(rx_release_value_o)
  );

  always #10 clk_i = ~clk_i;

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic tracker_result_t track_event(opcode_e op, logic [15:0] len, logic ok);
    tracker_result_t r;
    logic [3:0]  s;
    logic        found;
    logic [15:0] plen;
    logic [17:0] rx_end;
    logic [17:0] next_ptr;
    int n;
    r = '0;
    case (op)
      OP_SEND: begin
        // Scan from the head for the first free slot, wrapping once around the ring.
        s = tx_head;
        found = 1'b0;
        for (n = 0; n < TX_SLOTS; n++) begin
          if (!found) begin
            if (!slot_busy[s]) found = 1'b1;
            else s = s + 4'd1;
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end else begin
          plen = (len < MIN_FRAME) ? MIN_FRAME : len;
          slot_len[s] = plen;
          slot_busy[s] = 1'b1;
          r.slot_index = s;
          r.padded_length = plen;
          if (s == tx_head) begin
            r.kick_valid = 1'b1;
            r.kick_port = s[1:0];
            r.kick_slot = s;
            r.kick_length = plen;
          end
        end
      end
      OP_TXDONE: begin
        // The head is freed and advanced even when it was not busy.
        slot_busy[tx_head] = 1'b0;
        tx_head = tx_head + 4'd1;
        if (slot_busy[tx_head]) begin
          r.kick_valid = 1'b1;
          r.kick_port = tx_head[1:0];
          r.kick_slot = tx_head;
          r.kick_length = slot_len[tx_head];
        end
      end
      OP_RXHDR: begin
        rx_end = {2'b00, rx_offset} + RX_HDR_BYTES + {2'b00, len};
        if (ok && len < MAX_PACKET) begin
          r.rx_deliver = 1'b1;
          if (rx_end > RX_RING_BYTES) begin
            r.rx_split = 1'b1;
            r.rx_first_length = RX_FIRST_BASE - rx_offset;
          end
        end else begin
          r.status = ST_DROP;
        end
        // A dropped packet still moves the pointer past its header and body.
        next_ptr = (rx_end + 18'd3) & ~18'd3;
        rx_offset = next_ptr[15:0];
        r.rx_read_pointer = rx_offset;
        r.rx_release_value = rx_offset - RX_RELEASE_OFS;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Sends one request, with a random gap first, and records its expected result.
  task automatic send_request(opcode_e op, logic [15:0] len, logic ok);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    packet_length_i <= len;
    header_ok_i <= ok;
    do @(negedge clk_i); while (!in_ready_o);
    pending_results.push_back(track_event(op, len, ok));
    @(posedge clk_i);
  endtask

  task automatic check_field(string field, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Outputs are stable at the falling edge; a result seen valid and ready there is
  // taken at the next rising edge.
  always @(negedge clk_i) begin
    tracker_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual status %h",
                 $time, status_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 16'(exp_r.status), 16'(status_o));
        check_field("slot_index", 16'(exp_r.slot_index), 16'(slot_index_o));
        check_field("padded_length", exp_r.padded_length, padded_length_o);
        check_field("kick_valid", 16'(exp_r.kick_valid), 16'(kick_valid_o));
        check_field("kick_port", 16'(exp_r.kick_port), 16'(kick_port_o));
        check_field("kick_slot", 16'(exp_r.kick_slot), 16'(kick_slot_o));
        check_field("kick_length", exp_r.kick_length, kick_length_o);
        check_field("rx_deliver", 16'(exp_r.rx_deliver), 16'(rx_deliver_o));
        check_field("rx_split", 16'(exp_r.rx_split), 16'(rx_split_o));
        check_field("rx_first_length", exp_r.rx_first_length, rx_first_length_o);
        check_field("rx_read_pointer", exp_r.rx_read_pointer, rx_read_pointer_o);
        check_field("rx_release_value", exp_r.rx_release_value, rx_release_value_o);
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Short, long and minimum-boundary send lengths; the first one starts at the head.
  task automatic test_send_padding();
    send_request(OP_SEND, 16'd0, 1'b0);
    send_request(OP_SEND, 16'd59, 1'b1);
    send_request(OP_SEND, 16'd60, 1'b0);
    send_request(OP_SEND, 16'd61, 1'b1);
    send_request(OP_SEND, 16'hFFFF, 1'b0);
  endtask

  // Fill the remaining slots, then one more send must report a full ring.
  task automatic test_ring_full();
    int n;
    for (n = 0; n < TX_SLOTS - 5; n++)
      send_request(OP_SEND, 16'($urandom_range(65535)), 1'($urandom_range(1)));
    send_request(OP_SEND, 16'd1000, 1'b1);
  endtask

  // Completing the head starts the next busy slot; the freed slot is found by wrapping.
  task automatic test_tx_done_kick();
    send_request(OP_TXDONE, 16'd0, 1'b0);
    send_request(OP_SEND, 16'd200, 1'b0);
  endtask

  // Dropped and delivered headers, a split across the ring end and a wrapping advance.
  task automatic test_rx_header();
    send_request(OP_RXHDR, 16'd65520, 1'b0);
    send_request(OP_RXHDR, 16'd100, 1'b1);
    send_request(OP_RXHDR, 16'(MAX_PACKET - 1), 1'b1);
    send_request(OP_RXHDR, 16'(MAX_PACKET), 1'b1);
    send_request(OP_RXHDR, 16'd0, 1'b1);
    send_request(OP_RXHDR, 16'hFFFF, 1'b0);
  endtask

  task automatic test_unused_opcode();
    send_request(OP_NONE, 16'hFFFF, 1'b1);
  endtask

  // Random traffic in bursts that alternately fill and drain the transmit ring, so that
  // both the full ring and completions on a free head come up often.
  task automatic run_random_traffic(int count);
    int n;
    int pick;
    int send_pct;
    opcode_e op;
    logic [15:0] len;
    logic ok;
    send_pct = 55;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) send_pct = (send_pct == 55) ? 20 : 55;
      pick = $urandom_range(99);
      if (pick < send_pct) op = OP_SEND;
      else if (pick < 75) op = OP_TXDONE;
      else if (pick < 95) op = OP_RXHDR;
      else op = OP_NONE;
      ok = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (op == OP_SEND) begin
        if (pick < 25) len = 16'($urandom_range(59));
        else if (pick < 75) len = 16'($urandom_range(1514, 60));
        else len = 16'($urandom_range(65535));
      end else begin
        if (pick < 70) len = 16'($urandom_range(MAX_PACKET - 1));
        else if (pick < 80) len = 16'($urandom_range(MAX_PACKET + 7, MAX_PACKET - 8));
        else len = 16'($urandom_range(65535));
      end
      send_request(op, len, ok);
    end
  endtask

  initial begin
    int n;
    for (n = 0; n < TX_SLOTS; n++) begin
      slot_busy[n] = 1'b0;
      slot_len[n] = 16'd0;
    end
    tx_head = 4'd0;
    rx_offset = 16'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_send_padding();
    test_ring_full();
    test_tx_done_kick();
    test_rx_header();
    test_unused_opcode();

    run_random_traffic(PHASE_ITEMS);
    send_gap_pct = 78;
    recv_stall_pct = 9;
    run_random_traffic(PHASE_ITEMS);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    run_random_traffic(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Leave room for any stray result to show up.
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** nic_tx_rx_ring_tracker_core: PASSED **");
    end else begin
      $display("** nic_tx_rx_ring_tracker_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("** nic_tx_rx_ring_tracker_core: FAILED **");
    $finish;
  end

endmodule
